// ===== rtl/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// Request and result payloads, request kind codes, wildcard bytes and the
// verdict encoding.
// ----------------------------------------------------------------------------
package wpm_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } wpm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } wpm_out_t;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_SUBJECT = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  typedef enum logic [1:0] {
    VRD_RUN    = 2'd0,
    VRD_ACCEPT = 2'd1,
    VRD_FAIL   = 2'd2
  } verdict_t;

endpackage

// ===== rtl/wpm_pattern_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pattern_mem: pattern byte store
// One write port, two registered read ports at raddr and raddr + 1, with the
// byte written in the same cycle forwarded to a read port at that address.
// ----------------------------------------------------------------------------
module wpm_pattern_mem #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(PATTERN_MAX+1)-1:0] waddr,
  input  logic [7:0]                       wdata,
  input  logic [$clog2(PATTERN_MAX+1)-1:0] raddr,
  output logic [7:0]                       cur_sym,
  output logic [7:0]                       nxt_sym
);
  import wpm_pkg::*;

  localparam int AW = $clog2(PATTERN_MAX);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [LW:0] DEPTH = (LW+1)'(PATTERN_MAX);

  logic [7:0]  mem [PATTERN_MAX];
  logic [LW:0] ra0;
  logic [LW:0] ra1;
  logic [LW:0] wa;
  logic [AW-1:0] ix0;
  logic [AW-1:0] ix1;
  logic [7:0]  cur_sym_r;
  logic [7:0]  nxt_sym_r;

  assign ra0 = {1'b0, raddr};
  assign ra1 = ra0 + (LW+1)'(1);
  assign wa  = {1'b0, waddr};
  // out-of-range addresses are never consumed; park them on entry zero
  assign ix0 = (ra0 < DEPTH) ? ra0[AW-1:0] : '0;
  assign ix1 = (ra1 < DEPTH) ? ra1[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    cur_sym_r <= (we && wa == ra0) ? wdata : mem[ix0];
    nxt_sym_r <= (we && wa == ra1) ? wdata : mem[ix1];
  end

  assign cur_sym = cur_sym_r;
  assign nxt_sym = nxt_sym_r;

endmodule

// ===== rtl/wpm_match_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_match_ctrl: pattern load and match step
// Holds pattern length, position, verdict and overflow state, applies one
// request per cycle and produces the verdict on end of subject.
// ----------------------------------------------------------------------------
module wpm_match_ctrl #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  wpm_pkg::wpm_in_t                 item,
  input  logic [7:0]                       cur_sym,
  input  logic [7:0]                       nxt_sym,
  output logic                             mem_we,
  output logic [$clog2(PATTERN_MAX+1)-1:0] mem_waddr,
  output logic [7:0]                       mem_wdata,
  output logic [$clog2(PATTERN_MAX+1)-1:0] rd_addr,
  output logic                             res_valid,
  output wpm_pkg::wpm_out_t                res
);
  import wpm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [LW-1:0] PM_L = LW'(PATTERN_MAX);

  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  verdict_t      vrd_r, vrd_nxt;
  logic          ovf_r, ovf_nxt;
  logic          wild_r, wild_nxt;
  logic          pos_live;
  logic          star_last;
  logic          matched;

  assign pos_live  = pos_r < len_r;
  assign star_last = pos_live && (cur_sym == CH_STAR) && ((pos_r + LW'(1)) == len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pos_r  <= '0;
      vrd_r  <= VRD_RUN;
      ovf_r  <= 1'b0;
      wild_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      vrd_r  <= vrd_nxt;
      ovf_r  <= ovf_nxt;
      wild_r <= wild_nxt;
    end
  end

  always_comb begin
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    vrd_nxt   = vrd_r;
    ovf_nxt   = ovf_r;
    wild_nxt  = wild_r;
    mem_we    = 1'b0;
    res_valid = 1'b0;
    if (item_valid) begin
      unique case (item.kind)
        KIND_CLEAR: begin
          len_nxt  = '0;
          pos_nxt  = '0;
          vrd_nxt  = VRD_RUN;
          ovf_nxt  = 1'b0;
          wild_nxt = 1'b0;
        end
        KIND_APPEND: begin
          // drop '?' right after a wildcard star
          if (!(item.symbol == CH_ANY && wild_r)) begin
            if (len_r >= PM_L) begin
              ovf_nxt = 1'b1;
            end else begin
              mem_we   = 1'b1;
              len_nxt  = len_r + LW'(1);
              wild_nxt = (item.symbol == CH_STAR) && !wild_r;
            end
          end
        end
        KIND_SUBJECT: begin
          if (vrd_r == VRD_RUN) begin
            if (star_last) begin
              vrd_nxt = VRD_ACCEPT;
            end else if (!pos_live) begin
              vrd_nxt = VRD_FAIL;
            end else if (cur_sym == CH_STAR) begin
              // skip until the target byte shows up, then consume both
              if (nxt_sym == item.symbol) begin
                pos_nxt = pos_r + LW'(2);
              end
            end else if (cur_sym == CH_ANY || cur_sym == item.symbol) begin
              pos_nxt = pos_r + LW'(1);
            end else begin
              vrd_nxt = VRD_FAIL;
            end
          end
        end
        KIND_END: begin
          res_valid = 1'b1;
          pos_nxt   = '0;
          vrd_nxt   = VRD_RUN;
        end
      endcase
    end
  end

  always_comb begin
    unique case (vrd_r)
      VRD_ACCEPT: matched = 1'b1;
      VRD_FAIL:   matched = 1'b0;
      default:    matched = (pos_r == len_r) || star_last;
    endcase
  end

  assign mem_waddr            = len_r;
  assign mem_wdata            = item.symbol;
  assign rd_addr              = pos_nxt;
  assign res.matched          = matched;
  assign res.pattern_overflow = ovf_r;

  a_pos_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= len_r)
    else $error("pattern position beyond pattern length");

  a_len_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= PM_L)
    else $error("pattern length beyond store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.kind == KIND_CLEAR |=> len_r == '0 && pos_r == '0 && !ovf_r)
    else $error("clear did not empty the pattern");

endmodule

// ===== rtl/wildcard_pattern_matcher_core.sv =====
`timescale 1ns / 1ps
// Path: a request is registered in the request register on acceptance and
//   applied from it; the end-of-subject verdict is registered for out_valid.
// Throughput: one request per cycle while no end request waits on a stalled
//   verdict; the match step reads the pattern store's two registered ports.
// Reset: synchronous, active low; clears length, position, verdict, overflow
//   and handshake state. The pattern store is not cleared.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core: streaming glob matcher, top level
// Request register, match control with pattern store, and result register.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core #(
  parameter int PATTERN_MAX = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wpm_pkg::wpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wpm_pkg::wpm_out_t out_data
);
  import wpm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic        s1_valid_r;
  wpm_in_t     s1_item_r;
  logic        s1_adv;
  logic        out_valid_r;
  wpm_out_t    out_data_r;
  logic        mem_we;
  logic [LW-1:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic [LW-1:0] rd_addr;
  logic [7:0]  cur_sym;
  logic [7:0]  nxt_sym;
  logic        res_valid;
  wpm_out_t    res;

  // hold an end request while the previous verdict is still waiting
  assign s1_adv   = !(s1_item_r.kind == KIND_END && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  wpm_match_ctrl #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_valid_r && s1_adv),
    .item      (s1_item_r),
    .cur_sym   (cur_sym),
    .nxt_sym   (nxt_sym),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rd_addr   (rd_addr),
    .res_valid (res_valid),
    .res       (res)
  );

  wpm_pattern_mem #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (rd_addr),
    .cur_sym(cur_sym),
    .nxt_sym(nxt_sym)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_item_r.kind == KIND_END)
    else $error("input stalled behind a request that needs no result slot");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(out_valid_r && out_stall))
    else $error("verdict produced while the result register is held");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("held verdict changed or dropped");

endmodule
